// File: src/umpt_pkg.sv
package umpt_pkg;

  localparam int KEY_W   = 16;
  localparam int PRIO_W  = 32;
  localparam int RANK_W  = PRIO_W + KEY_W;
  localparam int ENTRY_W = 1 + PRIO_W + KEY_W;

  localparam logic [PRIO_W-1:0] PRIO_BIAS  = {1'b1, {(PRIO_W-1){1'b0}}};
  localparam logic [PRIO_W-1:0] PRIO_EMPTY = '1;

  typedef enum logic [1:0] {
    KIND_INSERT  = 2'd0,
    KIND_DEL_MAX = 2'd1,
    KIND_DEL_KEY = 2'd2,
    KIND_PEEK    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_NO_OP = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic scan;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic out_free;
  } dp_stat_t;

  // biased priority above key, compares as unsigned
  function automatic logic [RANK_W-1:0] to_rank(input logic [PRIO_W-1:0] prio,
                                                input logic [KEY_W-1:0] key);
    to_rank = {prio ^ PRIO_BIAS, key};
  endfunction

endpackage

// File: src/umpt_ram.sv
module umpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/umpt_ctrl.sv
module umpt_ctrl import umpt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  typedef enum logic [2:0] {
    CLEAR,
    IDLE,
    SCAN,
    DRAIN,
    FINISH
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CLEAR;
    end else begin
      case (state)
        CLEAR:   if (stat.cnt_last) state <= IDLE;
        IDLE:    if (in_valid) state <= SCAN;
        SCAN:    if (stat.cnt_last) state <= DRAIN;
        DRAIN:   state <= FINISH;
        FINISH:  if (stat.out_free) state <= IDLE;
        default: state <= CLEAR;
      endcase
    end
  end

  always_comb begin
    in_ready   = (state == IDLE);
    cmd.clear  = (state == CLEAR);
    cmd.load   = (state == IDLE) && in_valid;
    cmd.scan   = (state == SCAN);
    cmd.finish = (state == FINISH) && stat.out_free;
  end

endmodule

// File: src/umpt_dp.sv
module umpt_dp import umpt_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  input  kind_t             in_kind,
  input  logic [KEY_W-1:0]  in_key,
  input  logic [PRIO_W-1:0] in_prio,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              out_has,
  output logic [KEY_W-1:0]  out_key,
  output logic [PRIO_W-1:0] out_prio,
  output status_t           out_status
);

  localparam int AW = $clog2(CAPACITY);

  logic [AW-1:0]      cnt;
  logic               cnt_last;
  logic               rd_v;
  logic [AW-1:0]      ridx;
  logic [ENTRY_W-1:0] rdata;

  kind_t             req_kind;
  logic [KEY_W-1:0]  req_key;
  logic [PRIO_W-1:0] req_prio;

  logic              match_f, free_f, b1_f, b2_f, bx_f;
  logic [AW-1:0]     match_idx, free_idx, b1_idx;
  logic [RANK_W-1:0] b1_rank, b2_rank, bx_rank;

  logic              e_v;
  logic [KEY_W-1:0]  e_key;
  logic [RANK_W-1:0] e_rank;
  logic              is_match, gt1, gt2, gtx;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [ENTRY_W-1:0] wdata;
  logic               fin_we;
  logic [AW-1:0]      fin_addr;
  logic [ENTRY_W-1:0] fin_data;
  logic               res_f;
  logic [RANK_W-1:0]  res_rank;
  status_t            res_status;
  logic [RANK_W-1:0]  cand_rank;

  assign cnt_last      = (cnt == AW'(CAPACITY - 1));
  assign stat.cnt_last = cnt_last;
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.clear || cmd.scan) begin
      cnt <= cnt_last ? '0 : cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
    end else begin
      rd_v <= cmd.scan;
    end
    ridx <= cnt;
  end

  assign we    = cmd.clear || fin_we;
  assign waddr = cmd.clear ? cnt : fin_addr;
  assign wdata = cmd.clear ? '0 : fin_data;

  umpt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (cnt),
    .rdata (rdata)
  );

  // entry layout: key low, priority, valid on top
  assign e_v      = rdata[ENTRY_W-1];
  assign e_key    = rdata[KEY_W-1:0];
  assign e_rank   = to_rank(rdata[KEY_W +: PRIO_W], e_key);
  assign is_match = (e_key == req_key);
  assign gt1      = !b1_f || (e_rank > b1_rank);
  assign gt2      = !b2_f || (e_rank > b2_rank);
  assign gtx      = !bx_f || (e_rank > bx_rank);

  // top two overall, best apart from the request key, key hit, first free slot
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_kind <= in_kind;
      req_key  <= in_key;
      req_prio <= in_prio;
      match_f  <= 1'b0;
      free_f   <= 1'b0;
      b1_f     <= 1'b0;
      b2_f     <= 1'b0;
      bx_f     <= 1'b0;
    end else if (rd_v) begin
      if (e_v) begin
        if (is_match) begin
          match_f   <= 1'b1;
          match_idx <= ridx;
        end else if (gtx) begin
          bx_f    <= 1'b1;
          bx_rank <= e_rank;
        end
        if (gt1) begin
          b1_f    <= 1'b1;
          b1_rank <= e_rank;
          b1_idx  <= ridx;
          b2_f    <= b1_f;
          b2_rank <= b1_rank;
        end else if (gt2) begin
          b2_f    <= 1'b1;
          b2_rank <= e_rank;
        end
      end else if (!free_f) begin
        free_f   <= 1'b1;
        free_idx <= ridx;
      end
    end
  end

  assign cand_rank = to_rank(req_prio, req_key);

  always_comb begin
    fin_we     = 1'b0;
    fin_addr   = b1_idx;
    fin_data   = '0;
    res_f      = b1_f;
    res_rank   = b1_rank;
    res_status = ST_DONE;
    case (req_kind)
      KIND_INSERT: begin
        if (match_f || free_f) begin
          fin_we   = cmd.finish;
          fin_addr = match_f ? match_idx : free_idx;
          fin_data = {1'b1, req_prio, req_key};
          res_f    = 1'b1;
          res_rank = (bx_f && (bx_rank > cand_rank)) ? bx_rank : cand_rank;
        end else begin
          res_status = ST_FULL;
        end
      end
      KIND_DEL_MAX: begin
        if (b1_f) begin
          fin_we   = cmd.finish;
          res_f    = b2_f;
          res_rank = b2_rank;
        end else begin
          res_status = ST_NO_OP;
        end
      end
      KIND_DEL_KEY: begin
        if (match_f) begin
          fin_we   = cmd.finish;
          fin_addr = match_idx;
          res_f    = bx_f;
          res_rank = bx_rank;
        end else begin
          res_status = ST_NO_OP;
        end
      end
      default: begin
        res_status = ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.finish) begin
      out_has    <= res_f;
      out_key    <= res_f ? res_rank[KEY_W-1:0] : '0;
      out_prio   <= res_f ? (res_rank[RANK_W-1:KEY_W] ^ PRIO_BIAS) : PRIO_EMPTY;
      out_status <= res_status;
    end
  end

endmodule

// File: src/updatable_max_priority_table_unit.sv
// an accepted word passes a scan over the slot ram, a drain state and a finish
// state that waits for a free output register; no word is taken in between
// a finished result waits in the output register while the next word is taken
// reset: synchronous, active high; a clearing pass over every slot follows,
// during which s_axis_tready stays low
module updatable_max_priority_table_unit import umpt_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // key, priority_req
  input  logic [1:0]  s_axis_tuser,  // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // max_key, max_priority
  output logic [2:0]  m_axis_tuser   // has_max, status
);

  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic              out_has;
  logic [KEY_W-1:0]  out_key;
  logic [PRIO_W-1:0] out_prio;
  status_t           out_status;

  umpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  umpt_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_kind    (kind_t'(s_axis_tuser)),
    .in_key     (s_axis_tdata[KEY_W-1:0]),
    .in_prio    (s_axis_tdata[KEY_W +: PRIO_W]),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_has    (out_has),
    .out_key    (out_key),
    .out_prio   (out_prio),
    .out_status (out_status)
  );

  assign m_axis_tdata = {out_prio, out_key};
  assign m_axis_tuser = {out_status, out_has};

endmodule
